// ===== rtl/core/mcbs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the masked column boxcar smoother: sizes, beat formats and the
// structs passed between the front end, the remainder unit and the multiplier cells.
// No dependencies.
package mcbs_pkg;

   localparam int MAX_HALF_WIDTH = 8;
   localparam int MAX_COLUMNS    = 64;
   localparam int ROW_BITS       = 20;

   localparam int SLOTS      = 2 * MAX_HALF_WIDTH + 1;
   localparam int SLOT_BITS  = $clog2(SLOTS + 1);
   localparam int W_BITS     = $clog2(MAX_HALF_WIDTH + 1);
   localparam int COL_BITS   = $clog2(MAX_COLUMNS);
   localparam int HIST_DEPTH = SLOTS * MAX_COLUMNS;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   localparam int HW_BITS       = 4;
   localparam int CC_BITS       = 7;
   localparam int RECIP_BITS    = 25;
   localparam int CSR_DATA_BITS = 25;
   localparam int SAMPLE_BITS   = 32;
   localparam int ROW_OUT_BITS  = 20;
   localparam int COL_OUT_BITS  = 6;

   localparam int SUM_BITS   = 37;
   localparam int DIGIT_BITS = 13;
   localparam int DIGITS     = 3;
   localparam int MAG_BITS   = DIGIT_BITS * DIGITS;
   localparam int PROD_BITS  = DIGIT_BITS + RECIP_BITS;
   localparam int ACC_BITS   = SUM_BITS + RECIP_BITS - 1;
   localparam int FRAC_SHIFT = 24;

   localparam logic [ROW_BITS-1:0] ROW_MASK = '1;

   typedef enum logic [1:0] {
      CSR_HALF_WIDTH   = 2'd0,
      CSR_COLUMN_COUNT = 2'd1,
      CSR_WINDOW_RECIP = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          smooth_enable;
      logic                          frame_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] smoothed_value;
      logic [ROW_OUT_BITS-1:0]       row_index;
      logic [COL_OUT_BITS-1:0]       column_index;
   } rsp_type;

   typedef struct packed {
      logic [W_BITS-1:0]    w;
      logic [SLOT_BITS-1:0] span;
      logic [COL_BITS:0]    cols;
   } cfg_type;

   typedef struct packed {
      logic                          mask;
      logic signed [SAMPLE_BITS-1:0] value;
   } hist_type;

   typedef struct packed {
      logic                          valid;
      logic                          neg;
      logic                          mask;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [ROW_BITS-1:0]           row;
      logic [COL_BITS-1:0]           col;
   } pipe_type;

   typedef struct packed {
      logic [ACC_BITS-1:0] acc;
      logic [MAG_BITS-1:0] mult;
   } mul_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [SLOT_BITS-1:0] rem;
   } mod_status_type;

endpackage

// ===== rtl/core/mcbs_row_mod.sv =====
`timescale 1ns / 1ps
// Bit-serial remainder unit: current row modulo the window span, one row bit per cycle.
// Depends on mcbs_pkg.
module mcbs_row_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mcbs_pkg::ROW_BITS-1:0]  row,
   input  logic [mcbs_pkg::SLOT_BITS-1:0] span,
   output mcbs_pkg::mod_status_type       status
);
   import mcbs_pkg::*;

   localparam int CNT_BITS = $clog2(ROW_BITS + 1);
   localparam int IDX_BITS = $clog2(ROW_BITS);

   logic                 run_ff, run_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0] rem_ff, rem_in;
   logic [SLOT_BITS-1:0] rem_step;
   logic [SLOT_BITS:0]   trial;
   logic [IDX_BITS-1:0]  idx;

   always_comb begin
      idx   = IDX_BITS'(cnt_ff - 1'b1);
      trial = {rem_ff, row[idx]};
      // The partial remainder stays below span, so one subtract restores it.
      if (trial >= {1'b0, span}) begin
         trial = trial - {1'b0, span};
      end
      rem_step = trial[SLOT_BITS-1:0];

      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_BITS'(ROW_BITS);
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = rem_step;
         cnt_in = cnt_ff - 1'b1;
         run_in = (cnt_ff != CNT_BITS'(1));
      end

      status.busy = run_ff;
      status.done = run_ff && (cnt_ff == CNT_BITS'(1));
      status.rem  = rem_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
         rem_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== rtl/core/mcbs_front.sv =====
`timescale 1ns / 1ps
// Front end: row and column counters, sample history memory, per-column window sums
// and the sum magnitude that feeds the multiplier chain. Depends on mcbs_pkg, mcbs_row_mod.
module mcbs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          adv,
   input  logic                          cfg_write,
   input  mcbs_pkg::req_type             req,
   input  mcbs_pkg::cfg_type             cfg,
   output logic                          busy,
   output mcbs_pkg::pipe_type            pipe_out,
   output logic [mcbs_pkg::MAG_BITS-1:0] mag_out
);
   import mcbs_pkg::*;

   mod_status_type mod_st;

   logic [ROW_BITS-1:0]  cur_row_ff, cur_row_in;
   logic [COL_BITS-1:0]  cur_col_ff, cur_col_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [ROW_BITS-1:0]  data_rows_ff, data_rows_in;

   // Accept stage.
   logic [ROW_BITS-1:0]    row_a, drows_a, drows_new, erow_a, w_row;
   logic [COL_BITS-1:0]    col_raw, col_a;
   logic [COL_BITS:0]      col_inc;
   logic [SLOT_BITS-1:0]   slot_a, eslot_a, slot_inc, w_slot;
   logic                   fs_a, flush_a, mask_a, sub_a, emit_a, wrap_a;
   logic signed [SAMPLE_BITS-1:0] val_a;
   logic [HIST_AW-1:0]     addr_s, addr_e;

   // Read stage.
   hist_type               hist_mem [HIST_DEPTH];
   hist_type               hist_s_ff, hist_e_ff;
   logic [SUM_BITS-1:0]    sum_mem [MAX_COLUMNS];
   logic [SUM_BITS-1:0]    sum_rd_ff;
   logic [MAX_COLUMNS-1:0] sum_ok_ff, sum_ok_in;
   logic                   b_valid_ff;
   logic                   b_emit_ff, b_mask_ff, b_sub_ff, b_w0_ff, b_sv_ff, b_hit_ff;
   logic [COL_BITS-1:0]    b_col_ff;
   logic [ROW_BITS-1:0]    b_erow_ff;
   logic signed [SAMPLE_BITS-1:0] b_val_ff;
   logic [SUM_BITS-1:0]    b_fwd_ff;
   logic [SUM_BITS-1:0]    old_b, sub_b, add_b, sum_new_b;
   logic                   em_mask_b;
   logic signed [SAMPLE_BITS-1:0] em_val_b;

   // Sum and magnitude stages.
   pipe_type               c_pipe_ff, c_pipe_in;
   logic [SUM_BITS-1:0]    c_sum_ff;
   pipe_type               d_pipe_ff;
   logic [MAG_BITS-1:0]    d_mag_ff;
   logic [SUM_BITS-1:0]    c_abs;

   mcbs_row_mod u_row_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (cfg_write),
      .row    (cur_row_ff),
      .span   (cfg.span),
      .status (mod_st)
   );

   assign busy = mod_st.busy;

   always_comb begin
      fs_a    = req.frame_start;
      flush_a = req.kind;
      val_a   = flush_a ? '0 : req.sample;
      mask_a  = !flush_a && req.smooth_enable;
      w_row   = ROW_BITS'(cfg.w);
      w_slot  = SLOT_BITS'(cfg.w);

      row_a   = fs_a ? '0 : cur_row_ff;
      col_raw = fs_a ? '0 : cur_col_ff;
      slot_a  = fs_a ? '0 : slot_ff;
      drows_a = fs_a ? '0 : data_rows_ff;
      // A column register lowered under the running column folds back to column 0.
      col_a   = ({1'b0, col_raw} < cfg.cols) ? col_raw : '0;

      sub_a = row_a > ROW_BITS'({cfg.w, 1'b0});

      if (!flush_a && row_a >= drows_a) begin
         drows_new = (row_a == ROW_MASK) ? ROW_MASK : row_a + 1'b1;
      end else begin
         drows_new = drows_a;
      end

      erow_a = row_a - w_row;
      emit_a = (row_a >= w_row) && (erow_a < drows_new);

      if (slot_a >= w_slot) begin
         eslot_a = slot_a - w_slot;
      end else begin
         eslot_a = slot_a + cfg.span - w_slot;
      end
      slot_inc = (slot_a + 1'b1 == cfg.span) ? '0 : slot_a + 1'b1;

      col_inc = {1'b0, col_a} + 1'b1;
      wrap_a  = col_inc >= cfg.cols;

      addr_s = HIST_AW'(slot_a) * HIST_AW'(MAX_COLUMNS) + HIST_AW'(col_a);
      addr_e = HIST_AW'(eslot_a) * HIST_AW'(MAX_COLUMNS) + HIST_AW'(col_a);

      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      data_rows_in = data_rows_ff;
      slot_in      = slot_ff;
      if (accept) begin
         data_rows_in = drows_new;
         if (wrap_a) begin
            cur_col_in = '0;
            cur_row_in = row_a + 1'b1;
            slot_in    = (row_a == ROW_MASK) ? '0 : slot_inc;
         end else begin
            cur_col_in = col_inc[COL_BITS-1:0];
            cur_row_in = row_a;
            slot_in    = slot_a;
         end
      end else if (mod_st.done) begin
         slot_in = mod_st.rem;
      end

      // A frame start drops every column sum; it wins over the write of the beat in flight.
      sum_ok_in = sum_ok_ff;
      if (accept && fs_a) begin
         sum_ok_in = '0;
      end else if (adv && b_valid_ff) begin
         sum_ok_in[b_col_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         slot_ff      <= '0;
         data_rows_ff <= '0;
         sum_ok_ff    <= '0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         slot_ff      <= slot_in;
         data_rows_ff <= data_rows_in;
         sum_ok_ff    <= sum_ok_in;
      end
   end

   // History memory: one write and two reads per beat, read data registered.
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[addr_s] <= {mask_a, val_a};
         hist_s_ff        <= hist_mem[addr_s];
         hist_e_ff        <= hist_mem[addr_e];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && b_valid_ff) begin
         sum_mem[b_col_ff] <= sum_new_b;
      end
      if (accept) begin
         sum_rd_ff <= sum_mem[col_a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_col_ff  <= col_a;
         b_erow_ff <= erow_a;
         b_emit_ff <= emit_a;
         b_mask_ff <= mask_a;
         b_val_ff  <= val_a;
         b_sub_ff  <= sub_a;
         b_w0_ff   <= (cfg.w == '0);
         b_sv_ff   <= sum_ok_ff[col_a] && !fs_a;
         // The sum of the beat ahead is written at this same edge, so take it directly.
         b_hit_ff  <= b_valid_ff && (b_col_ff == col_a) && !fs_a;
         b_fwd_ff  <= sum_new_b;
      end
   end

   always_comb begin
      old_b     = b_hit_ff ? b_fwd_ff : (b_sv_ff ? sum_rd_ff : '0);
      sub_b     = b_sub_ff ? {{(SUM_BITS - SAMPLE_BITS){hist_s_ff.value[SAMPLE_BITS-1]}},
                              hist_s_ff.value} : '0;
      add_b     = {{(SUM_BITS - SAMPLE_BITS){b_val_ff[SAMPLE_BITS-1]}}, b_val_ff};
      sum_new_b = old_b - sub_b + add_b;
      // With a zero half width the emitted point is the one being written now.
      em_mask_b = b_w0_ff ? b_mask_ff : hist_e_ff.mask;
      em_val_b  = b_w0_ff ? b_val_ff : hist_e_ff.value;

      c_pipe_in.valid = b_valid_ff && b_emit_ff;
      c_pipe_in.neg   = sum_new_b[SUM_BITS-1];
      c_pipe_in.mask  = em_mask_b;
      c_pipe_in.value = em_val_b;
      c_pipe_in.row   = b_erow_ff;
      c_pipe_in.col   = b_col_ff;

      c_abs = c_pipe_ff.neg ? (~c_sum_ff + 1'b1) : c_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_pipe_ff.valid <= 1'b0;
         d_pipe_ff.valid <= 1'b0;
      end else if (adv) begin
         c_pipe_ff <= c_pipe_in;
         d_pipe_ff <= c_pipe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_sum_ff <= sum_new_b;
         d_mag_ff <= MAG_BITS'(c_abs);
      end
   end

   assign pipe_out = d_pipe_ff;
   assign mag_out  = d_mag_ff;

endmodule

// ===== rtl/core/mcbs_mul_cell.sv =====
`timescale 1ns / 1ps
// One cell of the scaling chain: folds the top digit of the sum magnitude into the
// product and hands the beat to the next cell. Depends on mcbs_pkg.
module mcbs_mul_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [mcbs_pkg::RECIP_BITS-1:0] recip,
   input  mcbs_pkg::pipe_type              pipe_in,
   input  mcbs_pkg::mul_type               mul_in,
   output mcbs_pkg::pipe_type              pipe_out,
   output mcbs_pkg::mul_type               mul_out
);
   import mcbs_pkg::*;

   pipe_type              pipe_ff;
   mul_type               mul_ff, mul_in_next;
   logic [DIGIT_BITS-1:0] digit;
   logic [PROD_BITS-1:0]  prod;

   always_comb begin
      digit            = mul_in.mult[MAG_BITS-1 -: DIGIT_BITS];
      prod             = PROD_BITS'(digit) * PROD_BITS'(recip);
      mul_in_next.acc  = (mul_in.acc << DIGIT_BITS) + ACC_BITS'(prod);
      mul_in_next.mult = mul_in.mult << DIGIT_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_ff <= mul_in_next;
      end
   end

   assign pipe_out = pipe_ff;
   assign mul_out  = mul_ff;

endmodule

// ===== rtl/core/masked_column_boxcar_smoother.sv =====
`timescale 1ns / 1ps
// Top level of the masked column boxcar smoother: register file, multiplier cell chain,
// final saturation and output skid stage. Depends on mcbs_pkg, mcbs_front, mcbs_mul_cell.
//
// Takes one beat per clock and gives one result beat per clock at most. A result passes
// through three front-end stages, three multiplier cells and the output register, and
// belongs to the point half_width rows earlier in the same column. After any register
// write the input stalls while a bit-serial unit recomputes the current row modulo the
// window span, one row bit per cycle. The output has a one-entry skid buffer; otherwise
// the input stalls only when that buffer is full.
module masked_column_boxcar_smoother (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mcbs_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mcbs_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_enable,
   input  mcbs_pkg::csr_index_type            csr_index,
   input  logic [mcbs_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import mcbs_pkg::*;

   localparam int QW = ACC_BITS + 1 - FRAC_SHIFT;

   logic [HW_BITS-1:0]    hw_ff;
   logic [CC_BITS-1:0]    cc_ff;
   logic [RECIP_BITS-1:0] recip_ff;
   cfg_type               cfg;

   logic                  accept, adv, front_busy;
   pipe_type              cell_pipe [DIGITS+1];
   mul_type               cell_mul [DIGITS+1];
   logic [MAG_BITS-1:0]   front_mag;

   logic signed [ACC_BITS:0]  prod_s;
   logic signed [QW-1:0]      quot;
   logic signed [SAMPLE_BITS-1:0] sat_val;
   rsp_type               rsp_in;
   logic                  new_valid, take;

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_type               out_data_ff, out_data_in;
   rsp_type               skid_data_ff, skid_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff    <= HW_BITS'(1);
         cc_ff    <= CC_BITS'(1);
         recip_ff <= RECIP_BITS'(5592405);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:   hw_ff    <= csr_write_data[HW_BITS-1:0];
            CSR_COLUMN_COUNT: cc_ff    <= csr_write_data[CC_BITS-1:0];
            CSR_WINDOW_RECIP: recip_ff <= csr_write_data[RECIP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.w    = (hw_ff > HW_BITS'(MAX_HALF_WIDTH)) ? W_BITS'(MAX_HALF_WIDTH) : W_BITS'(hw_ff);
      cfg.span = SLOT_BITS'({cfg.w, 1'b0}) + 1'b1;
      if (cc_ff == '0) begin
         cfg.cols = (COL_BITS + 1)'(1);
      end else if (cc_ff > CC_BITS'(MAX_COLUMNS)) begin
         cfg.cols = (COL_BITS + 1)'(MAX_COLUMNS);
      end else begin
         cfg.cols = (COL_BITS + 1)'(cc_ff);
      end
   end

   // The whole pipeline moves together and stops only while the skid entry is occupied.
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff || front_busy;
   assign accept    = req_valid && !req_stall;

   mcbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .adv       (adv),
      .cfg_write (csr_write_enable),
      .req       (req_data),
      .cfg       (cfg),
      .busy      (front_busy),
      .pipe_out  (cell_pipe[0]),
      .mag_out   (front_mag)
   );

   assign cell_mul[0].acc  = '0;
   assign cell_mul[0].mult = front_mag;

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      mcbs_mul_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .recip    (recip_ff),
         .pipe_in  (cell_pipe[i]),
         .mul_in   (cell_mul[i]),
         .pipe_out (cell_pipe[i+1]),
         .mul_out  (cell_mul[i+1])
      );
   end

   always_comb begin
      prod_s = cell_pipe[DIGITS].neg ? -$signed({1'b0, cell_mul[DIGITS].acc})
                                     : $signed({1'b0, cell_mul[DIGITS].acc});
      // An arithmetic shift floors toward minus infinity, as the scaling requires.
      quot   = $signed(prod_s[ACC_BITS:FRAC_SHIFT]);
      if (!quot[QW-1] && (|quot[QW-2:SAMPLE_BITS-1])) begin
         sat_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end else if (quot[QW-1] && !(&quot[QW-2:SAMPLE_BITS-1])) begin
         sat_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
         sat_val = quot[SAMPLE_BITS-1:0];
      end

      rsp_in.smoothed_value = cell_pipe[DIGITS].mask ? sat_val : cell_pipe[DIGITS].value;
      rsp_in.row_index      = ROW_OUT_BITS'(cell_pipe[DIGITS].row);
      rsp_in.column_index   = COL_OUT_BITS'(cell_pipe[DIGITS].col);

      new_valid = adv && cell_pipe[DIGITS].valid;
      take      = out_valid_ff && !rsp_stall;

      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = rsp_in;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_in;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // The skid entry is only ever filled behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while the output register is empty");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid entry filled although the output beat was free to leave");

   a_chain_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(cell_pipe[DIGITS]))
      else $error("multiplier chain moved while the skid entry was full");

endmodule

// ===== tb/masked_column_boxcar_smoother_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for masked_column_boxcar_smoother: directed and random beats
// checked against an in-bench column smoothing predictor. Depends on mcbs_pkg and the RTL.
module masked_column_boxcar_smoother_tb;
   import mcbs_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_BEATS  = 617;
   localparam longint SAT_HIGH  = 2147483647;
   localparam longint SAT_LOW   = -SAT_HIGH - 1;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   req_type                  req_data         = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write_enable = 1'b0;
   csr_index_type            csr_index        = CSR_HALF_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_write_data   = '0;

   // Predictor copy of the registers and of the per-column state.
   logic [HW_BITS-1:0]            half_width_reg;
   logic [CC_BITS-1:0]            column_count_reg;
   logic [RECIP_BITS-1:0]         recip_reg;
   logic signed [SAMPLE_BITS-1:0] row_samples [HIST_DEPTH];
   bit                            row_masks [HIST_DEPTH];
   logic [SUM_BITS-1:0]           window_sums [MAX_COLUMNS];
   int unsigned                   point_col;
   int unsigned                   point_row;
   int unsigned                   filled_rows;

   rsp_type     pending_points [$];
   int unsigned beats_sent     = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned stall_pct      = 0;

   masked_column_boxcar_smoother dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned effective_half_width();
      return (half_width_reg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : half_width_reg;
   endfunction

   function automatic int unsigned effective_columns();
      if (column_count_reg == 0) return 1;
      return (column_count_reg > MAX_COLUMNS) ? MAX_COLUMNS : column_count_reg;
   endfunction

   // Advances the predictor by one accepted beat; returns 1 when a point is emitted.
   function automatic bit smooth_point(input req_type beat, output rsp_type point);
      int unsigned                   w;
      int unsigned                   cols;
      int unsigned                   span;
      int unsigned                   row;
      int unsigned                   col;
      int unsigned                   slot;
      int unsigned                   erow;
      int unsigned                   eslot;
      longint                        sum;
      longint                        scaled;
      logic signed [SUM_BITS-1:0]    wrapped;
      logic signed [SAMPLE_BITS-1:0] value;
      bit                            masked;
      bit                            emitted;
      w      = effective_half_width();
      cols   = effective_columns();
      span   = 2 * w + 1;
      value  = beat.kind ? '0 : beat.sample;
      masked = !beat.kind && beat.smooth_enable;
      if (beat.frame_start) begin
         point_row   = 0;
         point_col   = 0;
         filled_rows = 0;
         foreach (window_sums[i]) window_sums[i] = '0;
      end
      row  = point_row;
      col  = (point_col < cols) ? point_col : 0;
      slot = (row % span) * MAX_COLUMNS + col;

      wrapped = window_sums[col];
      sum     = wrapped;
      if (row > 2 * w) sum -= row_samples[slot];
      sum += value;
      window_sums[col] = sum[SUM_BITS-1:0];
      wrapped          = window_sums[col];
      sum              = wrapped;

      row_samples[slot] = value;
      row_masks[slot]   = masked;
      if (!beat.kind && row >= filled_rows)
         filled_rows = (row == ROW_MASK) ? ROW_MASK : row + 1;

      emitted = 1'b0;
      point   = '0;
      if (row >= w && row - w < filled_rows) begin
         erow  = row - w;
         eslot = (erow % span) * MAX_COLUMNS + col;
         if (row_masks[eslot]) begin
            // Arithmetic shift floors toward minus infinity, as the scaling in the design does.
            scaled = (sum * longint'(recip_reg)) >>> FRAC_SHIFT;
            if (scaled > SAT_HIGH) scaled = SAT_HIGH;
            if (scaled < SAT_LOW) scaled = SAT_LOW;
            point.smoothed_value = scaled[SAMPLE_BITS-1:0];
         end else begin
            point.smoothed_value = row_samples[eslot];
         end
         point.row_index    = erow[ROW_OUT_BITS-1:0];
         point.column_index = col[COL_OUT_BITS-1:0];
         emitted            = 1'b1;
      end

      point_col = col + 1;
      if (point_col >= cols) begin
         point_col = 0;
         point_row = (row + 1) & ROW_MASK;
      end
      return emitted;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      int small_value;
      small_value = $urandom_range(0, 1048575);
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4, 5: return $urandom;
         default: return small_value - 524288;
      endcase
   endfunction

   function automatic req_type sample_beat(input logic [SAMPLE_BITS-1:0] value, input bit en,
                                           input bit fs);
      req_type beat;
      beat.kind          = 1'b0;
      beat.sample        = value;
      beat.smooth_enable = en;
      beat.frame_start   = fs;
      return beat;
   endfunction

   // The sample and enable of a flush beat are don't-care, so they carry noise.
   function automatic req_type flush_beat(input bit fs);
      req_type beat;
      beat.kind          = 1'b1;
      beat.sample        = $urandom;
      beat.smooth_enable = 1'($urandom_range(1));
      beat.frame_start   = fs;
      return beat;
   endfunction

   task automatic send_point(input req_type beat);
      rsp_type point;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      if (smooth_point(beat, point)) pending_points.push_back(point);
      beats_sent++;
   endtask

   // Waits until the block has drained, then writes all three registers.
   task automatic program_window(input int unsigned hw, input int unsigned cols,
                                 input int unsigned recip);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HALF_WIDTH;
      csr_write_data   <= CSR_DATA_BITS'(hw);
      @(posedge clock);
      half_width_reg   = HW_BITS'(hw);
      csr_index        <= CSR_COLUMN_COUNT;
      csr_write_data   <= CSR_DATA_BITS'(cols);
      @(posedge clock);
      column_count_reg = CC_BITS'(cols);
      csr_index        <= CSR_WINDOW_RECIP;
      csr_write_data   <= CSR_DATA_BITS'(recip);
      @(posedge clock);
      recip_reg        = RECIP_BITS'(recip);
      csr_write_enable <= 1'b0;
   endtask

   // One frame: rows of random points, with a little noise, then the flush beats.
   task automatic run_frame(input int unsigned rows);
      int unsigned w;
      int unsigned cols;
      int unsigned flushes;
      req_type     beat;
      w    = effective_half_width();
      cols = effective_columns();
      for (int unsigned r = 0; r < rows; r++) begin
         for (int unsigned c = 0; c < cols; c++) begin
            beat = sample_beat(random_sample(), 1'($urandom_range(1)), 1'b0);
            if ($urandom_range(99) < 3) beat = flush_beat(1'b0);
            beat.frame_start = (r == 0 && c == 0) || ($urandom_range(99) == 0);
            send_point(beat);
         end
      end
      flushes = w * cols;
      if ($urandom_range(4) == 0) flushes = $urandom_range(0, w * cols + cols);
      repeat (flushes) send_point(flush_beat(1'b0));
   endtask

   task automatic test_reset_defaults();
      send_idle_pct = 10;
      stall_pct     = 30;
      send_point(sample_beat(32'h7FFF_FFFF, 1'b0, 1'b0));
      send_point(sample_beat(32'h8000_0000, 1'b1, 1'b0));
      send_point(sample_beat(32'h0000_0000, 1'b1, 1'b0));
      send_point(sample_beat(32'hFFFF_FFFF, 1'b0, 1'b0));
      send_point(flush_beat(1'b0));
      send_point(flush_beat(1'b0));
   endtask

   task automatic test_saturation();
      program_window(2, 1, 25'h1FF_FFFF);
      send_point(sample_beat(32'h7FFF_FFFF, 1'b1, 1'b1));
      send_point(sample_beat(32'h7FFF_FFFF, 1'b1, 1'b0));
      send_point(sample_beat(32'h8000_0000, 1'b1, 1'b0));
      send_point(sample_beat(32'h8000_0000, 1'b1, 1'b0));
      send_point(flush_beat(1'b0));
      send_point(flush_beat(1'b0));
   endtask

   task automatic test_column_cut_and_restart();
      program_window(1, 3, 25'h055_5555);
      send_point(sample_beat(32'h0001_0000, 1'b1, 1'b1));
      send_point(sample_beat(32'hFFFE_0000, 1'b1, 1'b0));
      send_point(sample_beat(32'h0003_8000, 1'b0, 1'b0));
      send_point(sample_beat(32'h7FFF_0000, 1'b1, 1'b0));
      send_point(flush_beat(1'b0));
      send_point(sample_beat(32'h8000_0001, 1'b1, 1'b0));
      send_point(sample_beat(32'h0000_0001, 1'b1, 1'b0));
      send_point(sample_beat(32'h1234_5678, 1'b1, 1'b0));
      // Two columns are now done in this row, so the next beat wraps back to column zero.
      program_window(1, 2, 25'h0AA_AAAB);
      send_point(sample_beat(32'hDEAD_BEEF, 1'b1, 1'b0));
      send_point(sample_beat(32'h0000_FFFF, 1'b0, 1'b0));
      send_point(flush_beat(1'b0));
      send_point(flush_beat(1'b0));
      program_window(0, 1, 25'h100_0000);
      send_point(sample_beat(32'h0005_0000, 1'b1, 1'b1));
      send_point(sample_beat(32'hFFFF_8000, 1'b1, 1'b1));
   endtask

   task automatic test_random_traffic(input int unsigned sender_pct, input int unsigned rx_pct,
                                      input int unsigned budget);
      int unsigned first;
      int unsigned pick;
      int unsigned hw;
      int unsigned cc;
      int unsigned recip;
      int unsigned eff_w;
      send_idle_pct = sender_pct;
      stall_pct     = rx_pct;
      first         = beats_sent;
      while (beats_sent - first < budget) begin
         // Each run starts with one wide grid; the rest are mostly narrow.
         pick = (beats_sent == first) ? 0 : $urandom_range(19);
         if (pick == 0) begin
            hw = $urandom_range(0, 1);
            cc = $urandom_range(64, 127);
         end else begin
            hw = $urandom_range(0, 15);
            cc = (pick == 1) ? 0 : $urandom_range(1, 6);
         end
         eff_w = (hw > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : hw;
         case ($urandom_range(7))
            0: recip = 0;
            1: recip = 25'h1FF_FFFF;
            2: recip = $urandom_range(0, 25'h1FF_FFFF);
            default: recip = ((1 << 25) / (2 * eff_w + 1) + 1) / 2;
         endcase
         program_window(hw, cc, recip);
         repeat ($urandom_range(1, 3)) begin
            if (pick == 0) run_frame($urandom_range(1, 3));
            else run_frame($urandom_range(1, 2 * eff_w + 6));
         end
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected value %h row %0d column %0d, got value %h row %0d column %0d",
                  $realtime, what, want.smoothed_value, want.row_index, want.column_index,
                  got.smoothed_value, got.row_index, got.column_index);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            note_mismatch("unexpected beat", '0, rsp_data);
         end else begin
            want = pending_points.pop_front();
            if (rsp_data.smoothed_value !== want.smoothed_value ||
                rsp_data.row_index !== want.row_index ||
                rsp_data.column_index !== want.column_index)
               note_mismatch("wrong result", want, rsp_data);
         end
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      half_width_reg   = 1;
      column_count_reg = 1;
      recip_reg        = 25'd5592405;
      foreach (row_samples[i]) row_samples[i] = '0;
      foreach (row_masks[i]) row_masks[i] = 1'b0;
      foreach (window_sums[i]) window_sums[i] = '0;
      point_col   = 0;
      point_row   = 0;
      filled_rows = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_saturation();
      test_column_cut_and_restart();
      test_random_traffic(6, 56, RANDOM_BEATS);
      test_random_traffic(56, 6, RANDOM_BEATS);
      test_random_traffic(0, 0, RANDOM_BEATS);

      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
